// ===== design/fdcr_pkg.sv =====
// Shared types and constants for the frame demultiplexer with per-connection rings.
// Used by every module of the block and by its port checker; depends on nothing.
`timescale 1ns / 1ps

package fdcr_pkg;

    localparam int MAX_CONNS   = 4;
    localparam int RING_DEPTH  = 4096;
    localparam int FRAME_BYTES = 256;

    localparam int CONN_W      = $clog2(MAX_CONNS);
    localparam int RING_W      = $clog2(RING_DEPTH);
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int MEM_AW      = CONN_W + RING_W;
    localparam int MEM_DEPTH   = MAX_CONNS * RING_DEPTH;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Frame layout: magic, type, length low, length high, connection, payload.
    localparam int POS_MAGIC   = 0;
    localparam int POS_TYPE    = 1;
    localparam int POS_LEN_LO  = 2;
    localparam int POS_LEN_HI  = 3;
    localparam int POS_CONN    = 4;
    localparam int POS_PAYLOAD = 5;

    localparam logic [7:0] MAGIC_RESET     = 8'hCB;
    localparam logic [7:0] DATA_TYPE_RESET = 8'h86;

    localparam logic [1:0] CFG_FRAME_MAGIC = 2'd0;
    localparam logic [1:0] CFG_DATA_TYPE   = 2'd1;

    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_POP   = 2'd1,
        OP_OPEN  = 2'd2,
        OP_CLOSE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RK_FRAME = 2'd0,
        RK_BYTE  = 2'd1,
        RK_EMPTY = 2'd2,
        RK_DONE  = 2'd3
    } result_kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_POP_WAIT
    } back_state_t;

    // One classified request handed from the front end to the back end.
    typedef struct packed {
        op_t               kind;
        logic              push;
        logic              report;
        logic              fill_en;
        logic              conn_ok;
        logic [CONN_W-1:0] conn;
        logic [7:0]        data;
        logic [7:0]        rep_value;
    } cmd_t;

endpackage

// ===== design/fdcr_front.sv =====
// Front end: configuration registers, frame parser and request classifier.
// Depends on fdcr_pkg; feeds classified requests into fdcr_queue.
`timescale 1ns / 1ps

module fdcr_front import fdcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] op,
    input  logic [7:0] data_byte,
    input  logic [1:0] conn,
    output logic       q_valid,
    input  logic       q_ready,
    output cmd_t       q_data
);

    logic [7:0]       frame_magic_reg, frame_magic_next;
    logic [7:0]       data_type_reg, data_type_next;
    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic             magic_ok_reg, magic_ok_next;
    logic [7:0]       frame_type_reg, frame_type_next;
    logic [15:0]      length_reg, length_next;
    logic [7:0]       target_reg, target_next;

    logic             accept;
    logic             last_byte;
    logic             data_frame;
    logic             target_ok;
    logic             in_window;
    logic             push_cand;
    logic [15:0]      payload_pos;
    op_t              op_in;

    assign cfg_ready = 1'b1;
    assign in_stall  = !q_ready;
    assign accept    = in_valid && q_ready;
    assign op_in     = op_t'(op);

    always_comb
    begin
        frame_magic_next = frame_magic_reg;
        data_type_next   = data_type_reg;
        if (cfg_valid)
        begin
            if (cfg_index == CFG_FRAME_MAGIC)
                frame_magic_next = cfg_data;
            if (cfg_index == CFG_DATA_TYPE)
                data_type_next = cfg_data;
        end
    end

    // Header fields as they stand after the current byte is taken in.
    always_comb
    begin
        magic_ok_next   = magic_ok_reg;
        frame_type_next = frame_type_reg;
        length_next     = length_reg;
        target_next     = target_reg;
        case (byte_index_reg)
            IDX_W'(POS_MAGIC):  magic_ok_next = (data_byte == frame_magic_reg);
            IDX_W'(POS_TYPE):   frame_type_next = data_byte;
            IDX_W'(POS_LEN_LO): length_next = {length_reg[15:8], data_byte};
            IDX_W'(POS_LEN_HI): length_next = {data_byte, length_reg[7:0]};
            IDX_W'(POS_CONN):   target_next = data_byte;
            default: ;
        endcase
    end

    assign last_byte   = (byte_index_reg == IDX_W'(FRAME_BYTES - 1));
    assign byte_index_next = last_byte ? '0 : byte_index_reg + 1'b1;
    assign data_frame  = magic_ok_next && (frame_type_next == data_type_reg)
                         && (length_next != 16'd0);
    assign target_ok   = (int'(target_next) < MAX_CONNS);
    assign payload_pos = 16'(byte_index_reg) - 16'(POS_PAYLOAD);
    // Only the first length-1 payload bytes are taken, and none past the frame end.
    assign in_window   = (byte_index_reg >= IDX_W'(POS_PAYLOAD))
                         && (payload_pos < length_next - 16'd1);
    assign push_cand   = in_window && data_frame && target_ok;

    always_comb
    begin
        q_data.kind      = op_in;
        q_data.push      = 1'b0;
        q_data.report    = 1'b0;
        q_data.fill_en   = 1'b0;
        q_data.conn_ok   = (int'(conn) < MAX_CONNS);
        q_data.conn      = conn[CONN_W-1:0];
        q_data.data      = data_byte;
        q_data.rep_value = 8'd0;
        q_valid          = 1'b0;
        if (op_in == OP_FRAME)
        begin
            q_data.push      = push_cand;
            q_data.report    = last_byte;
            q_data.fill_en   = data_frame && target_ok;
            q_data.conn_ok   = target_ok;
            q_data.conn      = target_next[CONN_W-1:0];
            q_data.rep_value = magic_ok_next ? frame_type_next : 8'd0;
            q_valid          = in_valid && (push_cand || last_byte);
        end
        else
        begin
            q_valid = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_magic_reg <= MAGIC_RESET;
            data_type_reg   <= DATA_TYPE_RESET;
            byte_index_reg  <= '0;
            magic_ok_reg    <= 1'b0;
            frame_type_reg  <= '0;
            length_reg      <= '0;
            target_reg      <= '0;
        end
        else
        begin
            frame_magic_reg <= frame_magic_next;
            data_type_reg   <= data_type_next;
            if (accept && (op_in == OP_FRAME))
            begin
                byte_index_reg <= byte_index_next;
                magic_ok_reg   <= magic_ok_next;
                frame_type_reg <= frame_type_next;
                length_reg     <= length_next;
                target_reg     <= target_next;
            end
        end
    end

endmodule

// ===== design/fdcr_queue.sv =====
// Short request queue between the front end and the back end.
// Depends on fdcr_pkg for the request type and the queue depth.
`timescale 1ns / 1ps

module fdcr_queue import fdcr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_data,
    output logic rd_valid,
    input  logic rd_take,
    output cmd_t rd_data
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_write;
    logic              do_read;

    assign wr_ready = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_write = wr_valid && wr_ready;
    assign do_read  = rd_take && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_write ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_read ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_write && !do_read)
            count_next = count_reg + 1'b1;
        else if (do_read && !do_write)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== design/fdcr_back.sv =====
// Back end: ring memory, per-connection pointers and open flags, result register.
// Depends on fdcr_pkg; takes requests from fdcr_queue.
`timescale 1ns / 1ps

module fdcr_back import fdcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_take,
    input  cmd_t        q_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  value,
    output logic [11:0] fill_level
);

    logic [7:0]        ring_mem [MEM_DEPTH];
    logic [7:0]        rd_data_reg;

    back_state_t       state_reg, state_next;
    logic [RING_W-1:0] head_reg [MAX_CONNS];
    logic [RING_W-1:0] head_next [MAX_CONNS];
    logic [RING_W-1:0] tail_reg [MAX_CONNS];
    logic [RING_W-1:0] tail_next [MAX_CONNS];
    logic [MAX_CONNS-1:0] open_reg, open_next;
    logic [RING_W-1:0] pop_fill_reg, pop_fill_next;

    logic              out_valid_reg, out_valid_next;
    result_kind_t      out_kind_reg, out_kind_next;
    logic [7:0]        out_value_reg, out_value_next;
    logic [RING_W-1:0] out_fill_reg, out_fill_next;

    logic              needs_result;
    logic              out_free;
    logic              take;
    logic [CONN_W-1:0] c;
    logic [RING_W-1:0] head_c;
    logic [RING_W-1:0] tail_c;
    logic [RING_W-1:0] fill_c;
    logic [RING_W-1:0] fill_after;
    logic              empty_c;
    logic              do_push;
    logic              pop_go;
    logic              mem_we;
    logic              mem_re;

    assign c            = q_data.conn;
    assign head_c       = head_reg[c];
    assign tail_c       = tail_reg[c];
    assign fill_c       = tail_c - head_c;
    assign empty_c      = (head_c == tail_c);
    assign needs_result = (q_data.kind != OP_FRAME) || q_data.report;
    assign out_free     = !out_valid_reg || !out_stall;
    assign take         = (state_reg == BK_IDLE) && q_valid && (!needs_result || out_free);
    assign q_take       = take;
    assign do_push      = q_data.push && q_data.conn_ok && open_reg[c];
    assign pop_go       = take && (q_data.kind == OP_POP) && q_data.conn_ok && !empty_c;
    // A push into a full ring drops the oldest byte, so the fill stays at its top.
    assign fill_after   = (do_push && (fill_c != '1)) ? fill_c + 1'b1 : fill_c;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:     if (pop_go) state_next = BK_POP_WAIT;
            BK_POP_WAIT: state_next = BK_IDLE;
            default:     state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        open_next      = open_reg;
        pop_fill_next  = pop_fill_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        out_fill_next  = out_fill_reg;
        if (state_reg == BK_POP_WAIT)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = RK_BYTE;
            out_value_next = rd_data_reg;
            out_fill_next  = pop_fill_reg;
        end
        else if (take)
        begin
            case (q_data.kind)
                OP_FRAME:
                begin
                    if (do_push)
                    begin
                        mem_we       = 1'b1;
                        tail_next[c] = tail_c + 1'b1;
                        if (tail_c + 1'b1 == head_c)
                            head_next[c] = head_c + 1'b1;
                    end
                    if (q_data.report)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = RK_FRAME;
                        out_value_next = q_data.rep_value;
                        out_fill_next  = q_data.fill_en ? fill_after : '0;
                    end
                end
                OP_POP:
                begin
                    if (pop_go)
                    begin
                        mem_re        = 1'b1;
                        head_next[c]  = head_c + 1'b1;
                        pop_fill_next = fill_c - 1'b1;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = RK_EMPTY;
                        out_value_next = 8'd0;
                        out_fill_next  = '0;
                    end
                end
                OP_OPEN, OP_CLOSE:
                begin
                    if (q_data.conn_ok)
                    begin
                        open_next[c] = (q_data.kind == OP_OPEN);
                        head_next[c] = '0;
                        tail_next[c] = '0;
                    end
                    out_valid_next = 1'b1;
                    out_kind_next  = RK_DONE;
                    out_value_next = 8'd0;
                    out_fill_next  = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            open_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CONNS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_fill_reg  <= pop_fill_next;
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
        out_fill_reg  <= out_fill_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[{c, tail_c}] <= q_data.data;
        if (mem_re)
            rd_data_reg <= ring_mem[{c, head_c}];
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign value       = out_value_reg;
    assign fill_level  = 12'(out_fill_reg);

endmodule

// ===== design/frame_demux_conn_rings.sv =====
// Top level of the frame demultiplexer with per-connection receive rings.
// Depends on fdcr_pkg, fdcr_front, fdcr_queue and fdcr_back.
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// -------   ------------------   ---------------------------------------
// input     in_valid / in_stall  op, data_byte, conn
// output    out_valid/out_stall  result_kind, value, fill_level
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The front end takes one input request per cycle while the request queue has room.
// The back end retires one queued request per cycle unless a pop that finds data is
// waiting on the registered ring memory read, or a result is blocked by out_stall.
// Reset clears all pointers, open flags and parser state at once; the ring memory
// itself is not cleared, and only bytes written since a ring was opened are read.
// A stalled result waits in the output register while the front keeps accepting
// requests until the queue fills, and then in_stall rises.

module frame_demux_conn_rings import fdcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  data_byte,
    input  logic [1:0]  conn,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  value,
    output logic [11:0] fill_level
);

    // Requests classified by the front end. Frame bytes that are neither meant for a
    // ring nor close a frame are consumed by the parser and never queued.
    logic fq_valid;
    logic fq_ready;
    cmd_t fq_data;

    logic qb_valid;
    logic qb_take;
    cmd_t qb_data;

    fdcr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .data_byte (data_byte),
        .conn      (conn),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_data    (fq_data)
    );

    // The queue decouples parsing from ring updates, so a stalled result
    // does not immediately hold up the incoming byte stream.
    fdcr_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_take  (qb_take),
        .rd_data  (qb_data)
    );

    // The back end owns the ring memory, the head and tail pointers, the open
    // flags and the result register that drives the output channel.
    fdcr_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (qb_valid),
        .q_take      (qb_take),
        .q_data      (qb_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .value       (value),
        .fill_level  (fill_level)
    );

endmodule

// ===== design/fdcr_checker.sv =====
// Port-level checker for frame_demux_conn_rings, attached by the bind below.
// Depends on fdcr_pkg for the result kind codes.
`timescale 1ns / 1ps

module fdcr_checker import fdcr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  result_kind,
    input logic [7:0]  value,
    input logic [11:0] fill_level
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(result_kind) && $stable(value)
                                   && $stable(fill_level))
        else $error("stalled result changed");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == RK_EMPTY) |-> (value == 8'd0) && (fill_level == 12'd0))
        else $error("ring empty result carries data");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == RK_DONE) |-> (value == 8'd0) && (fill_level == 12'd0))
        else $error("open or close result carries data");

endmodule

bind frame_demux_conn_rings fdcr_checker u_fdcr_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .value       (value),
    .fill_level  (fill_level)
);
